/* rtl/c8x_pkg.sv */
// Shared types, codes and constants of the CHIP-8 instruction execute block.
package c8x_pkg;

    localparam int MEM_AW = 12;
    localparam int CNT_W  = 12;

    localparam logic [MEM_AW-1:0] PC_START  = 12'h200;
    localparam logic [MEM_AW-1:0] FONT_BASE = 12'h050;
    localparam logic [MEM_AW-1:0] FONT_END  = 12'h0A0;
    localparam logic [CNT_W-1:0]  MEM_LAST  = 12'hFFF;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_EXEC = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;

    localparam logic [7:0] KK_SKP   = 8'h9E;
    localparam logic [7:0] KK_SKNP  = 8'hA1;
    localparam logic [7:0] KK_LDDT  = 8'h07;
    localparam logic [7:0] KK_WAITK = 8'h0A;
    localparam logic [7:0] KK_SETDT = 8'h15;
    localparam logic [7:0] KK_SETST = 8'h18;
    localparam logic [7:0] KK_ADDI  = 8'h1E;
    localparam logic [7:0] KK_FONT  = 8'h29;
    localparam logic [7:0] KK_BCD   = 8'h33;
    localparam logic [7:0] KK_STORE = 8'h55;
    localparam logic [7:0] KK_LOAD  = 8'h65;

    localparam logic [3:0] ALU_MOV  = 4'h0;
    localparam logic [3:0] ALU_OR   = 4'h1;
    localparam logic [3:0] ALU_AND  = 4'h2;
    localparam logic [3:0] ALU_XOR  = 4'h3;
    localparam logic [3:0] ALU_ADD  = 4'h4;
    localparam logic [3:0] ALU_SUB  = 4'h5;
    localparam logic [3:0] ALU_SHR  = 4'h6;
    localparam logic [3:0] ALU_SUBN = 4'h7;
    localparam logic [3:0] ALU_SHL  = 4'hE;

    localparam logic [3:0] GRP_SYS  = 4'h0;
    localparam logic [3:0] GRP_JP   = 4'h1;
    localparam logic [3:0] GRP_CALL = 4'h2;
    localparam logic [3:0] GRP_SE   = 4'h3;
    localparam logic [3:0] GRP_SNE  = 4'h4;
    localparam logic [3:0] GRP_SER  = 4'h5;
    localparam logic [3:0] GRP_LD   = 4'h6;
    localparam logic [3:0] GRP_ADD  = 4'h7;
    localparam logic [3:0] GRP_ALU  = 4'h8;
    localparam logic [3:0] GRP_SNER = 4'h9;
    localparam logic [3:0] GRP_LDI  = 4'hA;
    localparam logic [3:0] GRP_JPV  = 4'hB;
    localparam logic [3:0] GRP_RND  = 4'hC;
    localparam logic [3:0] GRP_DRW  = 4'hD;
    localparam logic [3:0] GRP_KEY  = 4'hE;
    localparam logic [3:0] GRP_MISC = 4'hF;

    localparam logic [3:0] REG_F = 4'hF;

    localparam logic [7:0] FONT_GLYPHS [0:79] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_LOAD, ST_SREAD,
        ST_FETCH_HI, ST_FETCH_LO, ST_READ_X, ST_READ_Y, ST_READ_0, ST_EXEC,
        ST_FLAG, ST_D_ROW, ST_D_S0, ST_D_S1, ST_BCD,
        ST_ST_RD, ST_ST_WR, ST_LD_RD, ST_LD_WR, ST_IDXINC, ST_OUT
    } t_state;

    typedef enum logic [4:0] {
        UOP_NOP, UOP_CLEAR, UOP_CAPTURE, UOP_LOAD, UOP_SREAD,
        UOP_FETCH_HI, UOP_FETCH_LO, UOP_READ_X, UOP_READ_Y, UOP_READ_0, UOP_EXEC,
        UOP_FLAG, UOP_D_MRD, UOP_D_S0, UOP_D_S1, UOP_BCD,
        UOP_ST_RD, UOP_ST_WR, UOP_LD_RD, UOP_LD_WR, UOP_IDXINC, UOP_PUSH
    } t_uop;

    typedef struct packed {
        t_uop             uop;
        logic [CNT_W-1:0] count;
    } t_cmd;

    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] op;
        logic        row_out;
        logic        out_free;
    } t_status;

endpackage

/* rtl/chip8_instruction_execute_top.sv */
// CHIP-8 core top level: after reset a clearing pass loads all memory with zeros
// and the hex font at 0x50; no item is taken until it ends. Each item is captured
// and dispatched; a load or screen read then makes one access and an instruction
// fetches two opcode bytes, reads Vx, Vy and V0 and executes. A flag-writing ALU
// op adds a VF write, a draw a read and two screen steps per row, BCD three writes
// and a block load or store a read and a write per byte. One item is in work at a
// time; the result register lets the next item in while it waits.
module chip8_instruction_execute_top
    import c8x_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_action,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_keys,
    input  logic [7:0]  i_random_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_program_counter,
    output logic [15:0] o_opcode,
    output logic [7:0]  o_flag_register,
    output logic        o_waiting_for_key,
    output logic [31:0] o_screen_word,
    output logic [7:0]  o_delay_value,
    output logic [7:0]  o_sound_value,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data
);

    t_cmd    cmd;
    t_status status;

    c8x_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_status (status),
        .o_cmd    (cmd)
    );

    c8x_datapath u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_status          (status),
        .i_action          (i_action),
        .i_address         (i_address),
        .i_data            (i_data),
        .i_keys            (i_keys),
        .i_random_byte     (i_random_byte),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_program_counter (o_program_counter),
        .o_opcode          (o_opcode),
        .o_flag_register   (o_flag_register),
        .o_waiting_for_key (o_waiting_for_key),
        .o_screen_word     (o_screen_word),
        .o_delay_value     (o_delay_value),
        .o_sound_value     (o_sound_value)
    );

endmodule

/* rtl/c8x_ctrl.sv */
// Sequencer that steps the datapath through each action and instruction.
module c8x_ctrl
    import c8x_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [3:0]       op_x;
    logic [3:0]       op_n;
    logic [7:0]       op_kk;

    assign op_x  = i_status.op[11:8];
    assign op_n  = i_status.op[3:0];
    assign op_kk = i_status.op[7:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd.uop   = UOP_NOP;
        o_cmd.count = r_cnt;
        o_stall     = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.uop = UOP_CLEAR;
                if (r_cnt == MEM_LAST) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_cmd.uop = UOP_CAPTURE;
                    n_state   = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (i_status.action)
                    ACT_LOAD: n_state = ST_LOAD;
                    ACT_EXEC: n_state = ST_FETCH_HI;
                    ACT_READ: n_state = ST_SREAD;
                    default:  n_state = ST_OUT;
                endcase
            end
            ST_LOAD: begin
                o_cmd.uop = UOP_LOAD;
                n_state   = ST_OUT;
            end
            ST_SREAD: begin
                o_cmd.uop = UOP_SREAD;
                n_state   = ST_OUT;
            end
            ST_FETCH_HI: begin
                o_cmd.uop = UOP_FETCH_HI;
                n_state   = ST_FETCH_LO;
            end
            ST_FETCH_LO: begin
                o_cmd.uop = UOP_FETCH_LO;
                n_state   = ST_READ_X;
            end
            ST_READ_X: begin
                o_cmd.uop = UOP_READ_X;
                n_state   = ST_READ_Y;
            end
            ST_READ_Y: begin
                o_cmd.uop = UOP_READ_Y;
                n_state   = ST_READ_0;
            end
            ST_READ_0: begin
                o_cmd.uop = UOP_READ_0;
                n_state   = ST_EXEC;
            end
            ST_EXEC: begin
                o_cmd.uop = UOP_EXEC;
                n_cnt     = '0;
                n_state   = ST_OUT;
                case (i_status.op[15:12])
                    GRP_ALU: begin
                        if (op_n == ALU_ADD || op_n == ALU_SUB || op_n == ALU_SHR ||
                            op_n == ALU_SUBN || op_n == ALU_SHL) begin
                            n_state = ST_FLAG;
                        end
                    end
                    GRP_DRW: n_state = ST_D_ROW;
                    GRP_MISC: begin
                        if (op_kk == KK_BCD) begin
                            n_state = ST_BCD;
                        end else if (op_kk == KK_STORE) begin
                            n_state = ST_ST_RD;
                        end else if (op_kk == KK_LOAD) begin
                            n_state = ST_LD_RD;
                        end
                    end
                    default: n_state = ST_OUT;
                endcase
            end
            ST_FLAG: begin
                o_cmd.uop = UOP_FLAG;
                n_state   = ST_OUT;
            end
            ST_D_ROW: begin
                o_cmd.uop = UOP_D_MRD;
                if (r_cnt[3:0] == op_n || i_status.row_out) begin
                    n_state = ST_FLAG;
                end else begin
                    n_state = ST_D_S0;
                end
            end
            ST_D_S0: begin
                o_cmd.uop = UOP_D_S0;
                n_state   = ST_D_S1;
            end
            ST_D_S1: begin
                o_cmd.uop = UOP_D_S1;
                n_cnt     = r_cnt + 1'b1;
                n_state   = ST_D_ROW;
            end
            ST_BCD: begin
                o_cmd.uop = UOP_BCD;
                if (r_cnt[1:0] == 2'd2) begin
                    n_state = ST_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_ST_RD: begin
                o_cmd.uop = UOP_ST_RD;
                n_state   = ST_ST_WR;
            end
            ST_ST_WR: begin
                o_cmd.uop = UOP_ST_WR;
                if (r_cnt[3:0] == op_x) begin
                    n_state = ST_IDXINC;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = ST_ST_RD;
                end
            end
            ST_LD_RD: begin
                o_cmd.uop = UOP_LD_RD;
                n_state   = ST_LD_WR;
            end
            ST_LD_WR: begin
                o_cmd.uop = UOP_LD_WR;
                if (r_cnt[3:0] == op_x) begin
                    n_state = ST_IDXINC;
                end else begin
                    n_cnt   = r_cnt + 1'b1;
                    n_state = ST_LD_RD;
                end
            end
            ST_IDXINC: begin
                o_cmd.uop = UOP_IDXINC;
                n_state   = ST_OUT;
            end
            ST_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.uop = UOP_PUSH;
                    n_state   = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    a_draw_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_D_S0) |=> (r_state == ST_D_S1))
        else $error("draw row second word step skipped");

    a_out_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && i_status.out_free) |=> (r_state == ST_IDLE))
        else $error("result transfer did not return to idle");

    a_clear_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && r_cnt != MEM_LAST) |=> (r_state == ST_CLEAR))
        else $error("memory clearing pass left early");

endmodule

/* rtl/c8x_datapath.sv */
// Registers, memories, screen and execute logic of the CHIP-8 core.
module c8x_datapath
    import c8x_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic [1:0]  i_action,
    input  logic [11:0] i_address,
    input  logic [7:0]  i_data,
    input  logic [15:0] i_keys,
    input  logic [7:0]  i_random_byte,
    input  logic        i_cfg_we,
    input  logic        i_cfg_data,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_program_counter,
    output logic [15:0] o_opcode,
    output logic [7:0]  o_flag_register,
    output logic        o_waiting_for_key,
    output logic [31:0] o_screen_word,
    output logic [7:0]  o_delay_value,
    output logic [7:0]  o_sound_value
);

    logic [1:0]  r_action;
    logic [11:0] r_addr;
    logic [7:0]  r_data;
    logic [15:0] r_keys;
    logic [7:0]  r_rnd;

    logic [11:0] r_pc, n_pc;
    logic [11:0] r_i, n_i;
    logic [3:0]  r_sp, n_sp;
    logic [7:0]  r_dt, n_dt;
    logic [7:0]  r_st, n_st;
    logic [15:0] r_op, n_op;
    logic [7:0]  r_vx, n_vx;
    logic [7:0]  r_vy, n_vy;
    logic [7:0]  r_vf;
    logic        r_flag, n_flag;
    logic        r_wait, n_wait;
    logic [7:0]  r_line, n_line;
    logic        r_legacy;
    logic [11:0] r_stack [16];

    logic [7:0]  r_mem [4096];
    logic [7:0]  r_mem_q;
    logic        mem_we;
    logic [11:0] mem_a;
    logic [7:0]  mem_wd;

    logic [7:0]  r_rf [16];
    logic [15:0] r_rf_vld;
    logic [7:0]  r_rf_raw;
    logic        r_rf_rv;
    logic [7:0]  rf_q;
    logic        rf_we;
    logic [3:0]  rf_wa;
    logic [7:0]  rf_wd;
    logic [3:0]  rf_ra;

    logic [31:0] r_scr [64];
    logic [63:0] r_scr_vld;
    logic [31:0] r_scr_raw;
    logic        r_scr_rv;
    logic [31:0] scr_q;
    logic        scr_we;
    logic [5:0]  scr_wa;
    logic [31:0] scr_wd;
    logic [5:0]  scr_ra;
    logic        scr_clr;
    logic        stk_we;

    logic        r_out_valid;
    logic        out_free;

    logic [3:0]  op_x, op_y, op_n;
    logic [7:0]  op_kk;
    logic [11:0] op_nnn;
    logic [3:0]  sp_inc;

    logic [7:0]  alu_res;
    logic        alu_flag;
    logic        alu_ok;
    logic [8:0]  alu_sum;

    logic [3:0]  key_idx;
    logic        key_any;

    logic [7:0]  bcd_rem;
    logic [1:0]  bcd_h;
    logic [14:0] bcd_prod;
    logic [3:0]  bcd_t;
    logic [7:0]  bcd_o;

    logic [5:0]  row_sum;
    logic [7:0]  line;
    logic [39:0] wide;
    logic [31:0] mask0, mask1;
    logic [5:0]  w0, w1;
    logic [11:0] blk_a;
    logic [6:0]  font_idx;

    assign op_x   = r_op[11:8];
    assign op_y   = r_op[7:4];
    assign op_n   = r_op[3:0];
    assign op_kk  = r_op[7:0];
    assign op_nnn = r_op[11:0];
    assign sp_inc = r_sp + 4'd1;

    assign rf_q  = r_rf_rv ? r_rf_raw : 8'd0;
    assign scr_q = r_scr_rv ? r_scr_raw : 32'd0;

    assign row_sum = {1'b0, r_vy[4:0]} + {2'b00, i_cmd.count[3:0]};
    assign line    = (i_cmd.uop == UOP_D_S0) ? r_mem_q : r_line;
    assign wide    = {line, 32'd0} >> r_vx[4:0];
    assign mask0   = wide[39:8];
    assign mask1   = r_vx[5] ? 32'd0 : {wide[7:0], 24'd0};
    assign w0      = {row_sum[4:0], r_vx[5]};
    assign w1      = {row_sum[4:0], 1'b1};
    assign blk_a   = r_i + i_cmd.count;
    assign font_idx = 7'(i_cmd.count - FONT_BASE);

    assign out_free = !r_out_valid || !i_stall;

    assign o_status.action   = r_action;
    assign o_status.op       = r_op;
    assign o_status.row_out  = row_sum[5];
    assign o_status.out_free = out_free;
    assign o_valid           = r_out_valid;

    always_comb begin
        alu_sum  = {1'b0, r_vx} + {1'b0, r_vy};
        alu_res  = r_vx;
        alu_flag = r_flag;
        alu_ok   = 1'b1;
        case (op_n)
            ALU_MOV:  alu_res = r_vy;
            ALU_OR:   alu_res = r_vx | r_vy;
            ALU_AND:  alu_res = r_vx & r_vy;
            ALU_XOR:  alu_res = r_vx ^ r_vy;
            ALU_ADD: begin
                alu_res  = alu_sum[7:0];
                alu_flag = alu_sum[8];
            end
            ALU_SUB: begin
                alu_res  = r_vx - r_vy;
                alu_flag = (r_vx >= r_vy);
            end
            ALU_SHR: begin
                alu_res  = {1'b0, r_vx[7:1]};
                alu_flag = r_vx[0];
            end
            ALU_SUBN: begin
                alu_res  = r_vy - r_vx;
                alu_flag = (r_vy >= r_vx);
            end
            ALU_SHL: begin
                alu_res  = {r_vx[6:0], 1'b0};
                alu_flag = r_vx[7];
            end
            default: alu_ok = 1'b0;
        endcase
    end

    always_comb begin
        key_idx = 4'd0;
        key_any = |r_keys;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) begin
                key_idx = 4'(k);
            end
        end
    end

    always_comb begin
        if (r_vx >= 8'd200) begin
            bcd_h   = 2'd2;
            bcd_rem = r_vx - 8'd200;
        end else if (r_vx >= 8'd100) begin
            bcd_h   = 2'd1;
            bcd_rem = r_vx - 8'd100;
        end else begin
            bcd_h   = 2'd0;
            bcd_rem = r_vx;
        end
        bcd_prod = {8'd0, bcd_rem[6:0]} * 15'd205;
        bcd_t    = bcd_prod[14:11];
        bcd_o    = bcd_rem - ({4'd0, bcd_t} * 8'd10);
    end

    always_comb begin
        n_pc    = r_pc;
        n_i     = r_i;
        n_sp    = r_sp;
        n_dt    = r_dt;
        n_st    = r_st;
        n_op    = r_op;
        n_vx    = r_vx;
        n_vy    = r_vy;
        n_flag  = r_flag;
        n_wait  = r_wait;
        n_line  = r_line;
        mem_we  = 1'b0;
        mem_a   = r_pc;
        mem_wd  = r_data;
        rf_we   = 1'b0;
        rf_wa   = op_x;
        rf_wd   = 8'd0;
        rf_ra   = op_x;
        scr_we  = 1'b0;
        scr_wa  = w0;
        scr_wd  = 32'd0;
        scr_ra  = r_addr[5:0];
        scr_clr = 1'b0;
        stk_we  = 1'b0;
        case (i_cmd.uop)
            UOP_CLEAR: begin
                mem_we = 1'b1;
                mem_a  = i_cmd.count;
                if (i_cmd.count >= FONT_BASE && i_cmd.count < FONT_END) begin
                    mem_wd = FONT_GLYPHS[font_idx];
                end else begin
                    mem_wd = 8'd0;
                end
            end
            UOP_CAPTURE: begin
                n_op   = 16'd0;
                n_wait = 1'b0;
            end
            UOP_LOAD: begin
                mem_we = (r_action == ACT_LOAD);
                mem_a  = r_addr;
            end
            UOP_FETCH_HI: mem_a = r_pc;
            UOP_FETCH_LO: begin
                mem_a       = r_pc + 12'd1;
                n_op[15:8]  = r_mem_q;
            end
            UOP_READ_X: begin
                n_op[7:0] = r_mem_q;
                n_pc      = r_pc + 12'd2;
                rf_ra     = r_op[11:8];
            end
            UOP_READ_Y: begin
                n_vx  = rf_q;
                rf_ra = op_y;
            end
            UOP_READ_0: begin
                n_vy  = rf_q;
                rf_ra = 4'd0;
            end
            UOP_EXEC: begin
                case (r_op[15:12])
                    GRP_SYS: begin
                        if (r_op == OP_CLS) begin
                            scr_clr = 1'b1;
                        end else if (r_op == OP_RET) begin
                            n_pc = r_stack[r_sp];
                            n_sp = r_sp - 4'd1;
                        end
                    end
                    GRP_JP: n_pc = op_nnn;
                    GRP_CALL: begin
                        n_sp   = sp_inc;
                        stk_we = 1'b1;
                        n_pc   = op_nnn;
                    end
                    GRP_SE: if (r_vx == op_kk) n_pc = r_pc + 12'd2;
                    GRP_SNE: if (r_vx != op_kk) n_pc = r_pc + 12'd2;
                    GRP_SER: if (r_vx == r_vy) n_pc = r_pc + 12'd2;
                    GRP_SNER: if (r_vx != r_vy) n_pc = r_pc + 12'd2;
                    GRP_LD: begin
                        rf_we = 1'b1;
                        rf_wd = op_kk;
                    end
                    GRP_ADD: begin
                        rf_we = 1'b1;
                        rf_wd = r_vx + op_kk;
                    end
                    GRP_ALU: begin
                        rf_we  = alu_ok;
                        rf_wd  = alu_res;
                        n_flag = alu_flag;
                    end
                    GRP_LDI: n_i = op_nnn;
                    GRP_JPV: n_pc = op_nnn + {4'd0, rf_q};
                    GRP_RND: begin
                        rf_we = 1'b1;
                        rf_wd = r_rnd & op_kk;
                    end
                    GRP_DRW: n_flag = 1'b0;
                    GRP_KEY: begin
                        if (op_kk == KK_SKP && r_keys[r_vx[3:0]]) begin
                            n_pc = r_pc + 12'd2;
                        end else if (op_kk == KK_SKNP && !r_keys[r_vx[3:0]]) begin
                            n_pc = r_pc + 12'd2;
                        end
                    end
                    GRP_MISC: begin
                        case (op_kk)
                            KK_LDDT: begin
                                rf_we = 1'b1;
                                rf_wd = r_dt;
                            end
                            KK_WAITK: begin
                                if (key_any) begin
                                    rf_we = 1'b1;
                                    rf_wd = {4'd0, key_idx};
                                end else begin
                                    n_pc   = r_pc - 12'd2;
                                    n_wait = 1'b1;
                                end
                            end
                            KK_SETDT: n_dt = r_vx;
                            KK_SETST: n_st = r_vx;
                            KK_ADDI:  n_i = r_i + {4'd0, r_vx};
                            KK_FONT:  n_i = FONT_BASE + {2'd0, r_vx, 2'd0} + {4'd0, r_vx};
                            default:  n_i = r_i;
                        endcase
                    end
                    default: n_pc = r_pc;
                endcase
            end
            UOP_FLAG: begin
                rf_we = 1'b1;
                rf_wa = REG_F;
                rf_wd = {7'd0, r_flag};
            end
            UOP_D_MRD: begin
                mem_a  = blk_a;
                scr_ra = w0;
            end
            UOP_D_S0: begin
                n_line = r_mem_q;
                scr_we = 1'b1;
                scr_wa = w0;
                scr_wd = scr_q ^ mask0;
                n_flag = r_flag | (|(scr_q & mask0));
                scr_ra = w1;
            end
            UOP_D_S1: begin
                scr_we = !r_vx[5];
                scr_wa = w1;
                scr_wd = scr_q ^ mask1;
                n_flag = r_flag | (|(scr_q & mask1));
            end
            UOP_BCD: begin
                mem_we = 1'b1;
                mem_a  = blk_a;
                case (i_cmd.count[1:0])
                    2'd0:    mem_wd = {6'd0, bcd_h};
                    2'd1:    mem_wd = {4'd0, bcd_t};
                    default: mem_wd = bcd_o;
                endcase
            end
            UOP_ST_RD: rf_ra = i_cmd.count[3:0];
            UOP_ST_WR: begin
                mem_we = 1'b1;
                mem_a  = blk_a;
                mem_wd = rf_q;
            end
            UOP_LD_RD: mem_a = blk_a;
            UOP_LD_WR: begin
                rf_we = 1'b1;
                rf_wa = i_cmd.count[3:0];
                rf_wd = r_mem_q;
            end
            UOP_IDXINC: begin
                if (r_legacy) begin
                    n_i = r_i + {8'd0, op_x} + 12'd1;
                end
            end
            default: n_pc = r_pc;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == UOP_CAPTURE) begin
            r_action <= i_action;
            r_addr   <= i_address;
            r_data   <= i_data;
            r_keys   <= i_keys;
            r_rnd    <= i_random_byte;
        end
        r_vx   <= n_vx;
        r_vy   <= n_vy;
        r_line <= n_line;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc     <= PC_START;
            r_i      <= '0;
            r_sp     <= '0;
            r_dt     <= '0;
            r_st     <= '0;
            r_op     <= '0;
            r_flag   <= 1'b0;
            r_wait   <= 1'b0;
            r_legacy <= 1'b1;
            r_vf     <= '0;
            for (int s = 0; s < 16; s++) begin
                r_stack[s] <= '0;
            end
        end else begin
            r_pc   <= n_pc;
            r_i    <= n_i;
            r_sp   <= n_sp;
            r_dt   <= n_dt;
            r_st   <= n_st;
            r_op   <= n_op;
            r_flag <= n_flag;
            r_wait <= n_wait;
            if (i_cfg_we) begin
                r_legacy <= i_cfg_data;
            end
            if (rf_we && rf_wa == REG_F) begin
                r_vf <= rf_wd;
            end
            if (stk_we) begin
                r_stack[sp_inc] <= r_pc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_a] <= mem_wd;
        end
        r_mem_q <= r_mem[mem_a];
    end

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_wa] <= rf_wd;
        end
        r_rf_raw <= r_rf[rf_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
            r_rf_rv  <= 1'b0;
        end else begin
            if (rf_we) begin
                r_rf_vld[rf_wa] <= 1'b1;
            end
            r_rf_rv <= r_rf_vld[rf_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (scr_we) begin
            r_scr[scr_wa] <= scr_wd;
        end
        r_scr_raw <= r_scr[scr_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scr_vld <= '0;
            r_scr_rv  <= 1'b0;
        end else begin
            if (scr_clr) begin
                r_scr_vld <= '0;
            end else if (scr_we) begin
                r_scr_vld[scr_wa] <= 1'b1;
            end
            r_scr_rv <= r_scr_vld[scr_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.uop == UOP_PUSH) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.uop == UOP_PUSH) begin
            o_program_counter <= r_pc;
            o_opcode          <= r_op;
            o_flag_register   <= r_vf;
            o_waiting_for_key <= r_wait;
            o_screen_word     <= (r_action == ACT_READ) ? scr_q : 32'd0;
            o_delay_value     <= r_dt;
            o_sound_value     <= r_st;
        end
    end

endmodule

/* tb/tb.sv */
// Self-checking testbench for the CHIP-8 instruction execute block, with a shadow core model.
module tb;
    import c8x_pkg::*;

    localparam int LIMIT_CYCLES = 3000000;

    typedef struct {
        logic [11:0] pc;
        logic [15:0] op;
        logic [7:0]  vf;
        logic        waiting;
        logic [31:0] word;
        logic [7:0]  dt;
        logic [7:0]  st;
    } t_result;

    class chip8_shadow;
        logic [7:0]  mem [4096];
        logic [31:0] scr [64];
        logic [7:0]  v [16];
        logic [11:0] idx, pc;
        logic [11:0] stk [16];
        logic [3:0]  sp;
        logic [7:0]  dt, st;
        logic        legacy;
        t_result     exp_q [$];
        int          errors, mismatches, executed, draws;

        function new();
            foreach (mem[i]) mem[i] = 8'h00;
            for (int i = 0; i < 80; i++) mem[FONT_BASE + i] = FONT_GLYPHS[i];
            foreach (scr[i]) scr[i] = 32'h0;
            foreach (v[i]) v[i] = 8'h00;
            foreach (stk[i]) stk[i] = 12'h0;
            idx = 12'h0; pc = PC_START; sp = 4'h0; dt = 8'h0; st = 8'h0;
            legacy = 1'b1; errors = 0; mismatches = 0; executed = 0; draws = 0;
        endfunction

        function void skip_if(bit c);
            if (c) pc = pc + 12'd2;
        endfunction

        function void alu(logic [3:0] x, logic [3:0] y, logic [3:0] f);
            logic [7:0] a, b;
            logic [8:0] sum;
            a = v[x]; b = v[y];
            case (f)
                ALU_MOV:  v[x] = b;
                ALU_OR:   v[x] = a | b;
                ALU_AND:  v[x] = a & b;
                ALU_XOR:  v[x] = a ^ b;
                ALU_ADD: begin sum = a + b; v[x] = sum[7:0]; v[REG_F] = {7'b0, sum[8]}; end
                ALU_SUB: begin v[x] = a - b; v[REG_F] = {7'b0, a >= b}; end
                ALU_SHR: begin v[x] = a >> 1; v[REG_F] = {7'b0, a[0]}; end
                ALU_SUBN: begin v[x] = b - a; v[REG_F] = {7'b0, b >= a}; end
                ALU_SHL: begin v[x] = a << 1; v[REG_F] = {7'b0, a[7]}; end
                default: ;
            endcase
        endfunction

        function logic [7:0] draw(logic [7:0] vx, logic [7:0] vy, int rows);
            int x0, y0, pos;
            logic [7:0] line, hit;
            x0 = vx % 64; y0 = vy % 32; hit = 8'd0;
            for (int r = 0; r < rows; r++) begin
                line = mem[12'(idx + r)];
                if (y0 + r >= 32) break;
                for (int c = 0; c < 8; c++) begin
                    if (line[7-c] && x0 + c < 64) begin
                        pos = (y0 + r) * 64 + x0 + c;
                        if (scr[pos >> 5][31 - (pos & 31)]) hit = 8'd1;
                        scr[pos >> 5][31 - (pos & 31)] ^= 1'b1;
                    end
                end
            end
            return hit;
        endfunction

        function bit run(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd);
            logic [3:0] x, y;
            logic [7:0] kk, vx;
            logic [11:0] nnn;
            x = op[11:8]; y = op[7:4]; kk = op[7:0]; nnn = op[11:0]; vx = v[x];
            pc = pc + 12'd2;
            case (op[15:12])
                GRP_SYS:
                    if (op == OP_CLS) foreach (scr[i]) scr[i] = 32'h0;
                    else if (op == OP_RET) begin pc = stk[sp]; sp = sp - 4'd1; end
                GRP_JP:   pc = nnn;
                GRP_CALL: begin sp = sp + 4'd1; stk[sp] = pc; pc = nnn; end
                GRP_SE:   skip_if(vx == kk);
                GRP_SNE:  skip_if(vx != kk);
                GRP_SER:  skip_if(vx == v[y]);
                GRP_LD:   v[x] = kk;
                GRP_ADD:  v[x] = vx + kk;
                GRP_ALU:  alu(x, y, op[3:0]);
                GRP_SNER: skip_if(vx != v[y]);
                GRP_LDI:  idx = nnn;
                GRP_JPV:  pc = nnn + {4'h0, v[0]};
                GRP_RND:  v[x] = rnd & kk;
                GRP_DRW: begin draws++; v[REG_F] = draw(vx, v[y], op[3:0]); end
                GRP_KEY:
                    if (kk == KK_SKP) skip_if(keys[vx[3:0]]);
                    else if (kk == KK_SKNP) skip_if(!keys[vx[3:0]]);
                default:
                    case (kk)
                        KK_LDDT: v[x] = dt;
                        KK_WAITK: begin
                            for (int i = 0; i < 16; i++)
                                if (keys[i]) begin v[x] = 8'(i); return 1'b0; end
                            pc = pc - 12'd2;
                            return 1'b1;
                        end
                        KK_SETDT: dt = vx;
                        KK_SETST: st = vx;
                        KK_ADDI:  idx = idx + {4'h0, vx};
                        KK_FONT:  idx = FONT_BASE + 12'(5 * vx);
                        KK_BCD: begin
                            mem[idx] = 8'(vx / 100);
                            mem[12'(idx + 1)] = 8'((vx / 10) % 10);
                            mem[12'(idx + 2)] = 8'(vx % 10);
                        end
                        KK_STORE, KK_LOAD: begin
                            for (int i = 0; i <= x; i++)
                                if (kk == KK_STORE) mem[12'(idx + i)] = v[i];
                                else v[i] = mem[12'(idx + i)];
                            if (legacy) idx = idx + 12'(x) + 12'd1;
                        end
                        default: ;
                    endcase
            endcase
            return 1'b0;
        endfunction

        function void apply_item(logic [1:0] act, logic [11:0] addr, logic [7:0] data,
                                 logic [15:0] keys, logic [7:0] rnd);
            t_result r;
            r.op = 16'h0; r.waiting = 1'b0; r.word = 32'h0;
            if (act == ACT_LOAD) mem[addr] = data;
            else if (act == ACT_EXEC) begin
                r.op = {mem[pc], mem[12'(pc + 1)]};
                r.waiting = run(r.op, keys, rnd);
                executed++;
            end else if (act == ACT_READ) r.word = scr[addr[5:0]];
            r.pc = pc; r.vf = v[REG_F]; r.dt = dt; r.st = st;
            exp_q.push_back(r);
        endfunction

        function void match_result(t_result got);
            t_result e;
            if (exp_q.size() == 0) begin
                errors++;
                $display("unexpected result: pc=%h op=%h", got.pc, got.op);
                return;
            end
            e = exp_q.pop_front();
            if (got.pc !== e.pc || got.op !== e.op || got.vf !== e.vf ||
                got.waiting !== e.waiting || got.word !== e.word ||
                got.dt !== e.dt || got.st !== e.st) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp pc=%h op=%h vf=%h wk=%b w=%h dt=%h st=%h | got pc=%h op=%h vf=%h wk=%b w=%h dt=%h st=%h",
                             e.pc, e.op, e.vf, e.waiting, e.word, e.dt, e.st,
                             got.pc, got.op, got.vf, got.waiting, got.word, got.dt, got.st);
            end
        endfunction
    endclass

    logic        i_clk, i_rst_n, i_valid, o_stall, o_valid, i_stall;
    logic [1:0]  i_action;
    logic [11:0] i_address;
    logic [7:0]  i_data, i_random_byte;
    logic [15:0] i_keys;
    logic [11:0] o_program_counter;
    logic [15:0] o_opcode;
    logic [7:0]  o_flag_register, o_delay_value, o_sound_value;
    logic        o_waiting_for_key;
    logic [31:0] o_screen_word;
    logic        i_cfg_we, i_cfg_data;

    chip8_instruction_execute_top u_top (.*);

    chip8_shadow core = new();
    int send_idle, recv_idle, cycles, items;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout with %0d results pending", core.exp_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle);
        if (i_rst_n && o_valid && !i_stall)
            core.match_result('{o_program_counter, o_opcode, o_flag_register,
                                o_waiting_for_key, o_screen_word, o_delay_value,
                                o_sound_value});
    end

    task automatic transfer(logic [1:0] act, logic [11:0] addr, logic [7:0] data,
                            logic [15:0] keys, logic [7:0] rnd);
        while ($urandom_range(99) < send_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act; i_address <= addr; i_data <= data;
        i_keys <= keys; i_random_byte <= rnd;
        do @(posedge i_clk); while (o_stall);
        core.apply_item(act, addr, data, keys, rnd);
        items++;
    endtask

    task automatic run_op(logic [15:0] op, logic [15:0] keys, logic [7:0] rnd);
        transfer(ACT_LOAD, core.pc, op[15:8], 16'($urandom), 8'($urandom));
        transfer(ACT_LOAD, 12'(core.pc + 1), op[7:0], 16'($urandom), 8'($urandom));
        transfer(ACT_EXEC, 12'($urandom), 8'($urandom), keys, rnd);
    endtask

    task automatic drain();
        i_valid <= 1'b0;
        while (core.exp_q.size() != 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic set_legacy(logic val);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        core.legacy = val;
    endtask

    function automatic logic [15:0] random_op();
        logic [15:0] op;
        logic [7:0] kks [11];
        logic [3:0] fns [9];
        kks = '{KK_LDDT, KK_WAITK, KK_SETDT, KK_SETST, KK_ADDI, KK_FONT, KK_BCD,
                KK_STORE, KK_LOAD, KK_SKP, KK_SKNP};
        fns = '{ALU_MOV, ALU_OR, ALU_AND, ALU_XOR, ALU_ADD, ALU_SUB, ALU_SHR,
                ALU_SUBN, ALU_SHL};
        op = 16'($urandom);
        case (op[15:12])
            GRP_SYS:  if ($urandom_range(3) != 0) op = $urandom_range(1) ? OP_CLS : OP_RET;
            GRP_ALU:  if ($urandom_range(7) != 0) op[3:0] = fns[$urandom_range(8)];
            GRP_KEY:  if ($urandom_range(7) != 0) op[7:0] = kks[9 + $urandom_range(1)];
            GRP_MISC: if ($urandom_range(7) != 0) op[7:0] = kks[$urandom_range(8)];
            default: ;
        endcase
        return op;
    endfunction

    task automatic random_phase(int count);
        int sel;
        logic [15:0] keys;
        for (int n = 0; n < count; ) begin
            sel = $urandom_range(99);
            keys = ($urandom_range(3) == 0) ? 16'h0 : 16'($urandom);
            if (sel < 60) begin
                run_op(random_op(), keys, 8'($urandom));
                n += 3;
            end else begin
                if (sel < 75)
                    transfer(ACT_READ, 12'($urandom), 8'($urandom), 16'($urandom),
                             8'($urandom));
                else if (sel < 85)
                    transfer(ACT_LOAD, 12'($urandom), 8'($urandom), 16'($urandom),
                             8'($urandom));
                else if (sel < 90)
                    transfer(2'd3, 12'($urandom), 8'($urandom), 16'($urandom),
                             8'($urandom));
                else
                    transfer(ACT_EXEC, 12'($urandom), 8'($urandom), keys, 8'($urandom));
                n++;
            end
        end
    endtask

    initial begin
        cycles = 0; items = 0;
        send_idle = 0; recv_idle = 0;
        i_rst_n <= 1'b0; i_valid <= 1'b0; i_stall <= 1'b0;
        i_action <= ACT_LOAD; i_address <= 12'h0; i_data <= 8'h0;
        i_keys <= 16'h0; i_random_byte <= 8'h0;
        i_cfg_we <= 1'b0; i_cfg_data <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_op(16'h60FF, 16'hFFFF, 8'hFF);
        run_op(16'h8006, 16'h0, 8'h0);
        run_op(16'hF029, 16'h0, 8'h0);
        run_op(16'hD01F, 16'h0, 8'h0);
        run_op(16'hF00A, 16'h0, 8'h0);
        run_op(16'hF00A, 16'h8000, 8'h0);
        transfer(ACT_READ, 12'h000, 8'h0, 16'h0, 8'h0);
        transfer(ACT_READ, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
        transfer(2'd3, 12'hFFF, 8'hFF, 16'hFFFF, 8'hFF);
        transfer(ACT_LOAD, 12'hFFF, 8'hFF, 16'h0, 8'h0);

        send_idle = 20; recv_idle = 80;
        random_phase(330);
        set_legacy(1'b0);
        send_idle = 80; recv_idle = 20;
        random_phase(330);
        set_legacy(1'b1);
        send_idle = 0; recv_idle = 0;
        random_phase(200);
        set_legacy(1'b0);
        random_phase(160);

        drain();
        $display("covered %0d transfers, %0d instructions executed, %0d sprite draws",
                 items, core.executed, core.draws);
        $display("legacy index increment toggled across phases; %0d failures",
                 core.errors);
        if (core.errors == 0 && core.exp_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
